// ===== rtl/core/ffsp_pkg.sv =====
`timescale 1ns / 1ps

package ffsp_pkg;

    // Frame geometry
    localparam int unsigned FRAME_LEN = 16;
    localparam int unsigned IDX_W     = 4;   // index into the window
    localparam int unsigned CNT_W     = 5;   // window fill, 0..16
    localparam logic [IDX_W-1:0] SUM_LAST = 4'd13;  // last byte covered by the sum

    // Configuration register indexes
    localparam logic [2:0] REG_SYNC_FIRST  = 3'd0;
    localparam logic [2:0] REG_SYNC_SECOND = 3'd1;
    localparam logic [2:0] REG_LENGTH_MARK = 3'd2;
    localparam logic [2:0] REG_CMD_A       = 3'd3;
    localparam logic [2:0] REG_CMD_B       = 3'd4;
    localparam logic [2:0] REG_CMD_C       = 3'd5;
    localparam logic [2:0] REG_CMD_D       = 3'd6;

    // Result status codes
    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_BAD_CMD    = 3'd1;
    localparam logic [2:0] STATUS_BAD_LENGTH = 3'd2;
    localparam logic [2:0] STATUS_CMD_REPEAT = 3'd3;
    localparam logic [2:0] STATUS_CHECKSUM   = 3'd4;

    typedef logic [FRAME_LEN-1:0][7:0] t_win_bytes;

    // Window update strobes from the sequencer
    typedef struct packed {
        logic append;
        logic drop;
    } t_win_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESYNC,
        ST_SUM,
        ST_CHECK
    } t_state;

endpackage

// ===== rtl/core/fixed_frame_sync_parser_top.sv =====
`timescale 1ns / 1ps

// Channel   | Dir | Handshake                  | Contents
// ----------+-----+----------------------------+-----------------------------------------
// s_axis    | in  | s_axis_tvalid/tready       | tdata[7:0] rx_byte
// m_axis    | out | m_axis_tvalid/tready       | tdata: payload_front, payload_back,
//           |     |                            | frame_checksum; tuser: status
// APB       | cfg | psel/penable/pwrite/pready | 7 byte registers at 4*i
//
// Each byte enters in IDLE, then the resync walk drops leading bytes one at a
// time and ends in a closing RESYNC step. A full window then goes through the
// checksum add over bytes 0..13 and the check; a failed check drops a byte and
// walks again (up to 14 more drops). The worst case per byte is set by the single
// 16-bit adder and the walk.
// Reset is synchronous, active low: empty window, default registers.
// A result waits in the output register; the check cycle stalls only if the
// previous result has not been taken.
module fixed_frame_sync_parser_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // received bytes
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    // results
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,   // [47:0] payload_front, [95:48] payload_back,
                                         // [111:96] frame_checksum
    output logic [2:0]   m_axis_tuser    // [2:0] status
);

    // Configuration registers
    logic [7:0] r_sync_first, r_sync_second, r_length_mark;
    logic [7:0] r_cmd_a, r_cmd_b, r_cmd_c, r_cmd_d;
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= 8'hAA;
            r_sync_second <= 8'h55;
            r_length_mark <= 8'h02;
            r_cmd_a       <= 8'h82;
            r_cmd_b       <= 8'h83;
            r_cmd_c       <= 8'h84;
            r_cmd_d       <= 8'hA0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                ffsp_pkg::REG_SYNC_FIRST:  r_sync_first  <= pwdata[7:0];
                ffsp_pkg::REG_SYNC_SECOND: r_sync_second <= pwdata[7:0];
                ffsp_pkg::REG_LENGTH_MARK: r_length_mark <= pwdata[7:0];
                ffsp_pkg::REG_CMD_A:       r_cmd_a       <= pwdata[7:0];
                ffsp_pkg::REG_CMD_B:       r_cmd_b       <= pwdata[7:0];
                ffsp_pkg::REG_CMD_C:       r_cmd_c       <= pwdata[7:0];
                ffsp_pkg::REG_CMD_D:       r_cmd_d       <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (cfg_idx)
            ffsp_pkg::REG_SYNC_FIRST:  prdata = {24'd0, r_sync_first};
            ffsp_pkg::REG_SYNC_SECOND: prdata = {24'd0, r_sync_second};
            ffsp_pkg::REG_LENGTH_MARK: prdata = {24'd0, r_length_mark};
            ffsp_pkg::REG_CMD_A:       prdata = {24'd0, r_cmd_a};
            ffsp_pkg::REG_CMD_B:       prdata = {24'd0, r_cmd_b};
            ffsp_pkg::REG_CMD_C:       prdata = {24'd0, r_cmd_c};
            ffsp_pkg::REG_CMD_D:       prdata = {24'd0, r_cmd_d};
            default:                   prdata = 32'd0;
        endcase
    end

    // Sequencer and datapath state
    ffsp_pkg::t_state                r_state, n_state;
    logic [ffsp_pkg::CNT_W-1:0]      r_count, n_count;
    logic [ffsp_pkg::IDX_W-1:0]      r_sum_idx, n_sum_idx;
    logic [15:0]                     r_sum, n_sum;
    logic                            r_out_valid, n_out_valid;
    logic [2:0]                      r_status, n_status;
    logic [111:0]                    r_out_data, n_out_data;

    ffsp_pkg::t_win_ctrl             win_ctrl;
    ffsp_pkg::t_win_bytes            win;
    logic [7:0]                      rd_byte;

    ffsp_window u_window (
        .i_clk     (i_clk),
        .i_ctrl    (win_ctrl),
        .i_wr_idx  (r_count[ffsp_pkg::IDX_W-1:0]),
        .i_wr_byte (s_axis_tdata),
        .i_rd_idx  (r_sum_idx),
        .o_rd_byte (rd_byte),
        .o_bytes   (win)
    );

    // Window conditions
    logic       in_xfer, out_free, synced, need_drop, full, cmd_ok;
    logic [2:0] check_status;
    logic [15:0] got_sum;

    assign in_xfer   = s_axis_tvalid & s_axis_tready;
    assign out_free  = ~r_out_valid | m_axis_tready;
    assign synced    = (win[0] == r_sync_first) && (win[1] == r_sync_second);
    assign need_drop = (r_count >= ffsp_pkg::CNT_W'(2)) && !synced;
    assign full      = (r_count == ffsp_pkg::CNT_W'(ffsp_pkg::FRAME_LEN));
    assign got_sum   = {win[14], win[15]};
    assign cmd_ok    = (win[3] == r_cmd_a) || (win[3] == r_cmd_b) ||
                       (win[3] == r_cmd_c) || (win[3] == r_cmd_d);

    // Frame checks in priority order
    always_comb begin
        if (!cmd_ok) begin
            check_status = ffsp_pkg::STATUS_BAD_CMD;
        end else if (win[11] != r_length_mark) begin
            check_status = ffsp_pkg::STATUS_BAD_LENGTH;
        end else if (win[12] != win[3]) begin
            check_status = ffsp_pkg::STATUS_CMD_REPEAT;
        end else if (r_sum != got_sum) begin
            check_status = ffsp_pkg::STATUS_CHECKSUM;
        end else begin
            check_status = ffsp_pkg::STATUS_OK;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffsp_pkg::ST_IDLE: begin
                if (in_xfer) n_state = ffsp_pkg::ST_RESYNC;
            end
            ffsp_pkg::ST_RESYNC: begin
                if (need_drop) begin
                    n_state = ffsp_pkg::ST_RESYNC;
                end else if (full) begin
                    n_state = ffsp_pkg::ST_SUM;
                end else begin
                    n_state = ffsp_pkg::ST_IDLE;
                end
            end
            ffsp_pkg::ST_SUM: begin
                if (r_sum_idx == ffsp_pkg::SUM_LAST) n_state = ffsp_pkg::ST_CHECK;
            end
            ffsp_pkg::ST_CHECK: begin
                if (out_free) begin
                    if (check_status == ffsp_pkg::STATUS_OK) begin
                        n_state = ffsp_pkg::ST_IDLE;
                    end else begin
                        n_state = ffsp_pkg::ST_RESYNC;
                    end
                end
            end
            default: n_state = ffsp_pkg::ST_IDLE;
        endcase
    end

    // Datapath controls and next values
    always_comb begin
        s_axis_tready   = 1'b0;
        win_ctrl.append = 1'b0;
        win_ctrl.drop   = 1'b0;
        n_count         = r_count;
        n_sum_idx       = r_sum_idx;
        n_sum           = r_sum;
        n_out_valid     = r_out_valid & ~m_axis_tready;
        n_status        = r_status;
        n_out_data      = r_out_data;
        unique case (r_state)
            ffsp_pkg::ST_IDLE: begin
                s_axis_tready   = 1'b1;
                win_ctrl.append = s_axis_tvalid;
                if (s_axis_tvalid) n_count = r_count + 1'b1;
            end
            ffsp_pkg::ST_RESYNC: begin
                n_sum_idx = '0;
                n_sum     = '0;
                if (need_drop) begin
                    win_ctrl.drop = 1'b1;
                    n_count       = r_count - 1'b1;
                end
            end
            ffsp_pkg::ST_SUM: begin
                n_sum     = r_sum + {8'd0, rd_byte};
                n_sum_idx = r_sum_idx + 1'b1;
            end
            ffsp_pkg::ST_CHECK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = check_status;
                    if (check_status == ffsp_pkg::STATUS_OK) begin
                        n_out_data = {got_sum,
                                      win[8], win[9], win[10], win[11], win[12], win[13],
                                      win[2], win[3], win[4], win[5], win[6], win[7]};
                        n_count    = '0;
                    end else begin
                        n_out_data    = '0;
                        win_ctrl.drop = 1'b1;
                        n_count       = r_count - 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffsp_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_idx  <= n_sum_idx;
        r_sum      <= n_sum;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_status;

endmodule

// ===== rtl/core/ffsp_window.sv =====
`timescale 1ns / 1ps

// Byte window: append at the fill position, drop shifts everything down one.
module ffsp_window (
    input  logic                       i_clk,
    input  ffsp_pkg::t_win_ctrl        i_ctrl,
    input  logic [ffsp_pkg::IDX_W-1:0] i_wr_idx,
    input  logic [7:0]                 i_wr_byte,
    input  logic [ffsp_pkg::IDX_W-1:0] i_rd_idx,
    output logic [7:0]                 o_rd_byte,
    output ffsp_pkg::t_win_bytes       o_bytes
);

    ffsp_pkg::t_win_bytes r_bytes;
    ffsp_pkg::t_win_bytes n_bytes;

    // Next window contents
    always_comb begin
        n_bytes = r_bytes;
        if (i_ctrl.drop) begin
            for (int i = 0; i < ffsp_pkg::FRAME_LEN - 1; i++) begin
                n_bytes[i] = r_bytes[i+1];
            end
        end else if (i_ctrl.append) begin
            n_bytes[i_wr_idx] = i_wr_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

    assign o_rd_byte = r_bytes[i_rd_idx];
    assign o_bytes   = r_bytes;

endmodule

// ===== bench/fixed_frame_sync_parser_top_tb.sv =====
`timescale 1ns / 1ps

module fixed_frame_sync_parser_top_tb;

    localparam int unsigned CLK_HALF      = 10;
    localparam int unsigned SETTLE_CYCLES = 64;   // outlasts the slowest byte
    localparam int unsigned PHASE_BYTES   = 400;
    localparam int unsigned PHASE_COUNT   = 5;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam logic [2:0]  REG_SPARE     = 3'd7;  // unmapped address, writes ignored

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] front;
        logic [47:0] back;
        logic [15:0] checksum;
    } t_frame_result;

    typedef enum int {
        FAULT_NONE,
        FAULT_CMD,
        FAULT_LENGTH,
        FAULT_REPEAT,
        FAULT_SUM
    } t_frame_fault;

    typedef enum int {
        FILL_RANDOM,
        FILL_HIGH,
        FILL_LOW
    } t_payload_fill;

    // DUT ports
    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         psel          = 1'b0;
    logic         penable       = 1'b0;
    logic         pwrite        = 1'b0;
    logic [4:0]   paddr         = '0;
    logic [31:0]  pwdata        = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = '0;   // [7:0] rx_byte
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;         // [47:0] payload_front, [95:48] payload_back,
                                        // [111:96] frame_checksum
    logic [2:0]   m_axis_tuser;         // [2:0] status

    // Shadow registers and window of the frame predictor
    logic [7:0]    cfg_reg [0:6];
    logic [7:0]    win [0:15];
    int unsigned   win_fill = 0;

    // Stimulus and scoreboard
    logic [7:0]    rx_backlog [$];
    t_frame_result pending_results [$];
    t_frame_result predicted;
    int unsigned   queued_count    = 0;
    int unsigned   accepted_count  = 0;
    int unsigned   results_checked = 0;
    int unsigned   mismatch_count  = 0;
    int unsigned   status_seen [0:7];
    int unsigned   settings_used   = 1;
    bit            steady_flow     = 1'b0;
    int unsigned   gap_left        = 0;
    int unsigned   stall_left      = 0;
    bit            stall_armed     = 1'b0;

    fixed_frame_sync_parser_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Frame predictor
    // ---------------------------------------------------------------
    function automatic bit is_command(input logic [7:0] code);
        return code == cfg_reg[ffsp_pkg::REG_CMD_A] || code == cfg_reg[ffsp_pkg::REG_CMD_B] ||
               code == cfg_reg[ffsp_pkg::REG_CMD_C] || code == cfg_reg[ffsp_pkg::REG_CMD_D];
    endfunction

    function automatic void drop_oldest();
        for (int k = 0; k < 15; k++) win[k] = win[k+1];
        if (win_fill > 0) win_fill--;
    endfunction

    // Walk the window until it starts on the sync pair or runs short
    function automatic void seek_sync();
        while (win_fill >= 2 &&
               !(win[0] == cfg_reg[ffsp_pkg::REG_SYNC_FIRST] &&
                 win[1] == cfg_reg[ffsp_pkg::REG_SYNC_SECOND]))
            drop_oldest();
    endfunction

    function automatic bit parse_rx_byte(input logic [7:0] rx, output t_frame_result res);
        logic [15:0] sum;
        logic [15:0] got;
        res = '0;
        if (win_fill >= ffsp_pkg::FRAME_LEN) drop_oldest();
        win[win_fill] = rx;
        win_fill++;
        seek_sync();
        if (win_fill < ffsp_pkg::FRAME_LEN) return 1'b0;

        sum = '0;
        for (int k = 0; k <= ffsp_pkg::SUM_LAST; k++) sum = sum + {8'h00, win[k]};
        got = {win[14], win[15]};

        if (!is_command(win[3]))
            res.status = ffsp_pkg::STATUS_BAD_CMD;
        else if (win[11] != cfg_reg[ffsp_pkg::REG_LENGTH_MARK])
            res.status = ffsp_pkg::STATUS_BAD_LENGTH;
        else if (win[12] != win[3])
            res.status = ffsp_pkg::STATUS_CMD_REPEAT;
        else if (sum != got)
            res.status = ffsp_pkg::STATUS_CHECKSUM;
        else
            res.status = ffsp_pkg::STATUS_OK;

        if (res.status == ffsp_pkg::STATUS_OK) begin
            res.front    = {win[2], win[3], win[4], win[5], win[6], win[7]};
            res.back     = {win[8], win[9], win[10], win[11], win[12], win[13]};
            res.checksum = got;
            win_fill     = 0;
        end else begin
            drop_oldest();
            seek_sync();
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Byte driver: one transfer per backlog entry, outside steady flow with random gaps
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (parse_rx_byte(s_axis_tdata, predicted))
                    pending_results.push_back(predicted);
                accepted_count++;
                gap_left = steady_flow ? 0 : $urandom_range(0, 8);
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (rx_backlog.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= rx_backlog.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: random stall per result outside steady flow, in-order compare
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_frame_result want;
        t_frame_result seen;
        bit            next_ready;
        bit            taken;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left  = 0;
            stall_armed = 1'b0;
        end else begin
            taken = m_axis_tvalid && m_axis_tready;
            if (taken) begin
                seen.status   = m_axis_tuser;
                seen.front    = m_axis_tdata[47:0];
                seen.back     = m_axis_tdata[95:48];
                seen.checksum = m_axis_tdata[111:96];
                stall_armed   = 1'b0;
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected result status=%0d front=%h back=%h sum=%h",
                                 $realtime, seen.status, seen.front, seen.back,
                                 seen.checksum);
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    status_seen[want.status]++;
                    if (seen.status !== want.status || seen.front !== want.front ||
                        seen.back !== want.back || seen.checksum !== want.checksum) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"%0t: result %0d mismatch: status %0d/%0d ",
                                      "front %h/%h back %h/%h sum %h/%h (exp/act)"},
                                     $realtime, results_checked, want.status, seen.status,
                                     want.front, seen.front, want.back, seen.back,
                                     want.checksum, seen.checksum);
                    end
                end
            end else if (m_axis_tvalid && !stall_armed) begin
                stall_left  = $urandom_range(0, 8);
                stall_armed = 1'b1;
            end

            if (steady_flow) begin
                next_ready = 1'b1;
            end else if (stall_armed && !taken) begin
                if (stall_left > 0) begin
                    stall_left--;
                    next_ready = 1'b0;
                end else begin
                    next_ready = 1'b1;
                end
            end else begin
                next_ready = 1'b0;
            end
            m_axis_tready <= next_ready;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_rx(input logic [7:0] b);
        rx_backlog.push_back(b);
        queued_count++;
    endtask

    // Build one frame from the current settings, optionally broken, and
    // queue its first keep bytes
    task automatic queue_frame(input t_frame_fault fault, input int keep,
                               input int cmd_sel, input t_payload_fill fill);
        logic [7:0]  fr [0:15];
        logic [15:0] sum;
        logic [7:0]  cmd;
        int          sel;
        sel = (cmd_sel < 0) ? $urandom_range(0, 3) : cmd_sel;
        case (sel)
            0:       cmd = cfg_reg[ffsp_pkg::REG_CMD_A];
            1:       cmd = cfg_reg[ffsp_pkg::REG_CMD_B];
            2:       cmd = cfg_reg[ffsp_pkg::REG_CMD_C];
            default: cmd = cfg_reg[ffsp_pkg::REG_CMD_D];
        endcase
        for (int k = 2; k < 16; k++) begin
            case (fill)
                FILL_HIGH: fr[k] = 8'hFF;
                FILL_LOW:  fr[k] = 8'h00;
                default:   fr[k] = 8'($urandom_range(0, 255));
            endcase
        end
        fr[0]  = cfg_reg[ffsp_pkg::REG_SYNC_FIRST];
        fr[1]  = cfg_reg[ffsp_pkg::REG_SYNC_SECOND];
        fr[3]  = cmd;
        fr[11] = cfg_reg[ffsp_pkg::REG_LENGTH_MARK];
        fr[12] = cmd;
        case (fault)
            FAULT_CMD: begin
                do fr[3] = 8'($urandom_range(0, 255)); while (is_command(fr[3]));
                fr[12] = fr[3];
            end
            FAULT_LENGTH: fr[11] = fr[11] ^ 8'($urandom_range(1, 255));
            FAULT_REPEAT: fr[12] = fr[3] ^ 8'($urandom_range(1, 255));
            default: ;
        endcase
        sum = '0;
        for (int k = 0; k <= ffsp_pkg::SUM_LAST; k++) sum = sum + {8'h00, fr[k]};
        if (fault == FAULT_SUM) sum = sum ^ 16'($urandom_range(1, 65535));
        fr[14] = sum[15:8];
        fr[15] = sum[7:0];
        for (int k = 0; k < keep; k++) push_rx(fr[k]);
    endtask

    // Mostly well-formed frames, plus broken frames, noise and cut-off frames
    task automatic queue_random_traffic(input int unsigned n_bytes);
        int unsigned start;
        int unsigned pick;
        start = queued_count;
        while (queued_count - start < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                queue_frame(FAULT_NONE, 16, -1, FILL_RANDOM);
            else if (pick < 80)
                queue_frame(t_frame_fault'($urandom_range(FAULT_CMD, FAULT_SUM)), 16, -1,
                            FILL_RANDOM);
            else if (pick < 90)
                repeat ($urandom_range(1, 6)) push_rx(8'($urandom_range(0, 255)));
            else
                queue_frame(FAULT_NONE, $urandom_range(1, 15), -1, FILL_RANDOM);
        end
    endtask

    // Wait until every byte is in and every result is out, then let the
    // block finish any walk that yields no result
    task automatic wait_drained();
        do @(posedge i_clk);
        while (accepted_count != queued_count || pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        logic [23:0] upper;
        upper = 24'($urandom);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {upper, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx != REG_SPARE) cfg_reg[idx] = value;
    endtask

    task automatic program_config(input logic [7:0] s1, input logic [7:0] s2,
                                  input logic [7:0] len, input logic [7:0] ca,
                                  input logic [7:0] cb, input logic [7:0] cc,
                                  input logic [7:0] cd);
        write_reg(ffsp_pkg::REG_SYNC_FIRST, s1);
        write_reg(ffsp_pkg::REG_SYNC_SECOND, s2);
        write_reg(ffsp_pkg::REG_LENGTH_MARK, len);
        write_reg(ffsp_pkg::REG_CMD_A, ca);
        write_reg(ffsp_pkg::REG_CMD_B, cb);
        write_reg(ffsp_pkg::REG_CMD_C, cc);
        write_reg(ffsp_pkg::REG_CMD_D, cd);
        write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
        settings_used++;
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        logic [7:0] rnd_sync;
        logic [7:0] rnd_cmd;
        cfg_reg[ffsp_pkg::REG_SYNC_FIRST]  = 8'hAA;
        cfg_reg[ffsp_pkg::REG_SYNC_SECOND] = 8'h55;
        cfg_reg[ffsp_pkg::REG_LENGTH_MARK] = 8'h02;
        cfg_reg[ffsp_pkg::REG_CMD_A]       = 8'h82;
        cfg_reg[ffsp_pkg::REG_CMD_B]       = 8'h83;
        cfg_reg[ffsp_pkg::REG_CMD_C]       = 8'h84;
        cfg_reg[ffsp_pkg::REG_CMD_D]       = 8'hA0;
        for (int k = 0; k < 8; k++) status_seen[k] = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: leading junk, all-ones payload frame, short window left open
        push_rx(8'h00);
        push_rx(8'hFF);
        queue_frame(FAULT_NONE, 16, 0, FILL_HIGH);
        queue_frame(FAULT_NONE, 7, 3, FILL_LOW);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                1: program_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hFD, 8'hFC);
                2: program_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03);
                3: program_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                  8'($urandom), 8'($urandom), 8'($urandom));
                4: begin
                    // equal sync bytes and a single repeated command
                    rnd_sync = 8'($urandom);
                    rnd_cmd  = 8'($urandom);
                    program_config(rnd_sync, rnd_sync, 8'($urandom), rnd_cmd, rnd_cmd,
                                   rnd_cmd, rnd_cmd);
                end
                default: ;
            endcase
            steady_flow = (phase == 2);
            queue_random_traffic(PHASE_BYTES);
            wait_drained();
        end

        $display("Sent %0d bytes under %0d register settings, checked %0d results",
                 accepted_count, settings_used, results_checked);
        $display("  ok %0d, bad command %0d, bad length %0d, repeat %0d, checksum %0d",
                 status_seen[ffsp_pkg::STATUS_OK], status_seen[ffsp_pkg::STATUS_BAD_CMD],
                 status_seen[ffsp_pkg::STATUS_BAD_LENGTH],
                 status_seen[ffsp_pkg::STATUS_CMD_REPEAT],
                 status_seen[ffsp_pkg::STATUS_CHECKSUM]);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Timeout: %0d of %0d bytes taken, %0d results outstanding",
                 accepted_count, queued_count, pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
